// File: sv/cc_pkg.sv
// Shared constants and types for the Chaikin corner-cutting smoother.
package cc_pkg;

    localparam int CC_MAX_LEVELS   = 4;
    localparam int CC_COORD_WIDTH  = 32;
    localparam int CC_TAG_WIDTH    = 16;
    localparam int CC_LEVELS_W     = 3;
    localparam int CC_QUEUE_DEPTH  = 4;

    // Flags that travel with every point through the cascade
    typedef struct packed {
        logic                   path_end;  // point closes the polyline
        logic                   run_last;  // final word caused by one input word
        logic [CC_LEVELS_W-1:0] nlev;      // clamped number of active levels
    } cc_flags_t;

endpackage

// File: sv/cc_front.sv
// Front end: takes input words and level writes, tags each point with its level count.
module cc_front #(
    parameter int MAX_LEVELS  = cc_pkg::CC_MAX_LEVELS,
    parameter int COORD_WIDTH = cc_pkg::CC_COORD_WIDTH,
    parameter int TAG_WIDTH   = cc_pkg::CC_TAG_WIDTH
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // px, py, pz, point_tag
    input  logic [((3*COORD_WIDTH+TAG_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                       s_axis_tlast,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [cc_pkg::CC_LEVELS_W-1:0]             cfg_data,
    output logic                                       q_valid,
    input  logic                                       q_ready,
    output logic [2:0][COORD_WIDTH-1:0]                q_coord,
    output logic [TAG_WIDTH-1:0]                       q_tag,
    output cc_pkg::cc_flags_t                          q_flags
);
    import cc_pkg::*;

    logic [CC_LEVELS_W-1:0] levels_reg;
    logic [CC_LEVELS_W-1:0] nlev;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= CC_LEVELS_W'(1);
        end
        else if (cfg_valid)
        begin
            levels_reg <= cfg_data;
        end
    end

    // zero acts as one, anything above the built depth as the built depth
    always_comb
    begin
        if (levels_reg == '0)
            nlev = CC_LEVELS_W'(1);
        else if (levels_reg > CC_LEVELS_W'(MAX_LEVELS))
            nlev = CC_LEVELS_W'(MAX_LEVELS);
        else
            nlev = levels_reg;
    end

    assign q_valid       = s_axis_tvalid;
    assign s_axis_tready = q_ready;
    assign q_coord[0]    = s_axis_tdata[COORD_WIDTH-1:0];
    assign q_coord[1]    = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign q_coord[2]    = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign q_tag         = s_axis_tdata[3*COORD_WIDTH+TAG_WIDTH-1:3*COORD_WIDTH];

    always_comb
    begin
        q_flags          = '0;
        q_flags.path_end = s_axis_tlast;
        q_flags.run_last = 1'b1;
        q_flags.nlev     = nlev;
    end

endmodule

// File: sv/cc_queue.sv
// Short FIFO between the front end and the smoothing cascade.
module cc_queue #(
    parameter int COORD_WIDTH = cc_pkg::CC_COORD_WIDTH,
    parameter int TAG_WIDTH   = cc_pkg::CC_TAG_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0][COORD_WIDTH-1:0] in_coord,
    input  logic [TAG_WIDTH-1:0]        in_tag,
    input  cc_pkg::cc_flags_t           in_flags,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0][COORD_WIDTH-1:0] out_coord,
    output logic [TAG_WIDTH-1:0]        out_tag,
    output cc_pkg::cc_flags_t           out_flags
);
    import cc_pkg::*;

    localparam int WORD_W = 3*COORD_WIDTH + TAG_WIDTH + $bits(cc_flags_t);
    localparam int PTR_W  = $clog2(CC_QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(CC_QUEUE_DEPTH + 1);

    logic [WORD_W-1:0] slot_reg [CC_QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CNT_W'(CC_QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    assign {out_flags, out_tag, out_coord} = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= {in_flags, in_tag, in_coord};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CC_QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CC_QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: sv/cc_level.sv
// One smoothing level: cuts corners between the held point and each new point.
module cc_level #(
    parameter int LEVEL_IDX   = 0,
    parameter int COORD_WIDTH = cc_pkg::CC_COORD_WIDTH,
    parameter int TAG_WIDTH   = cc_pkg::CC_TAG_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0][COORD_WIDTH-1:0] in_coord,
    input  logic [TAG_WIDTH-1:0]        in_tag,
    input  cc_pkg::cc_flags_t           in_flags,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0][COORD_WIDTH-1:0] out_coord,
    output logic [TAG_WIDTH-1:0]        out_tag,
    output cc_pkg::cc_flags_t           out_flags
);
    import cc_pkg::*;

    typedef enum logic [1:0] {
        EMIT_PASS = 2'd0,
        EMIT_Q    = 2'd1,
        EMIT_R    = 2'd2
    } emit_t;

    // working word
    logic                        cur_valid_reg;
    logic [2:0][COORD_WIDTH-1:0] cur_coord_reg;
    logic [TAG_WIDTH-1:0]        cur_tag_reg;
    cc_flags_t                   cur_flags_reg;
    logic [1:0]                  phase_reg;
    // level state
    logic [2:0][COORD_WIDTH-1:0] prev_coord_reg;
    logic [TAG_WIDTH-1:0]        prev_tag_reg;
    logic                        have_prev_reg;
    // output register
    logic                        out_valid_reg;
    logic [2:0][COORD_WIDTH-1:0] out_coord_reg;
    logic [TAG_WIDTH-1:0]        out_tag_reg;
    cc_flags_t                   out_flags_reg;

    logic                        active;
    logic [1:0]                  n_outs;
    logic                        final_ph;
    logic                        out_load;
    logic                        take;
    logic                        accept;
    emit_t                       sel;
    logic [2:0][COORD_WIDTH-1:0] mix_q;
    logic [2:0][COORD_WIDTH-1:0] mix_r;
    logic [2:0][COORD_WIDTH-1:0] emit_coord;
    logic [TAG_WIDTH-1:0]        emit_tag;
    cc_flags_t                   emit_flags;

    assign active   = (cur_flags_reg.nlev > CC_LEVELS_W'(LEVEL_IDX));
    assign n_outs   = active ? ((have_prev_reg ? 2'd2 : 2'd1) + {1'b0, cur_flags_reg.path_end})
                             : 2'd1;
    assign final_ph = (phase_reg == n_outs - 2'd1);
    assign out_load = cur_valid_reg && (!out_valid_reg || out_ready);
    assign take     = out_load && final_ph;
    assign in_ready = !cur_valid_reg || take;
    assign accept   = in_valid && in_ready;

    // floor((3a + b) / 4) in two bits of headroom; the result stays between a and b
    for (genvar k = 0; k < 3; k++)
    begin : g_mix
        logic signed [COORD_WIDTH+1:0] p0_ext;
        logic signed [COORD_WIDTH+1:0] p1_ext;
        logic signed [COORD_WIDTH+1:0] sum_q;
        logic signed [COORD_WIDTH+1:0] sum_r;

        assign p0_ext = {{2{prev_coord_reg[k][COORD_WIDTH-1]}}, prev_coord_reg[k]};
        assign p1_ext = {{2{cur_coord_reg[k][COORD_WIDTH-1]}}, cur_coord_reg[k]};
        assign sum_q  = p0_ext + (p0_ext <<< 1) + p1_ext;
        assign sum_r  = p1_ext + (p1_ext <<< 1) + p0_ext;
        assign mix_q[k] = sum_q[COORD_WIDTH+1:2];
        assign mix_r[k] = sum_r[COORD_WIDTH+1:2];
    end

    always_comb
    begin
        if (!active || !have_prev_reg)
            sel = EMIT_PASS;
        else if (phase_reg == 2'd0)
            sel = EMIT_Q;
        else if (phase_reg == 2'd1)
            sel = EMIT_R;
        else
            sel = EMIT_PASS;
    end

    always_comb
    begin
        unique case (sel)
            EMIT_Q:
            begin
                emit_coord = mix_q;
                emit_tag   = prev_tag_reg;
            end
            EMIT_R:
            begin
                emit_coord = mix_r;
                emit_tag   = cur_tag_reg;
            end
            default:
            begin
                emit_coord = cur_coord_reg;
                emit_tag   = cur_tag_reg;
            end
        endcase
    end

    always_comb
    begin
        emit_flags          = cur_flags_reg;
        emit_flags.run_last = cur_flags_reg.run_last && final_ph;
        // only the repeated closing point carries the end mark
        if (active)
            emit_flags.path_end = cur_flags_reg.path_end && final_ph;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_valid_reg <= 1'b1;
                phase_reg     <= '0;
            end
            else if (take)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (out_load)
            begin
                phase_reg <= phase_reg + 2'd1;
            end

            if (take && active)
                have_prev_reg <= !cur_flags_reg.path_end;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_coord_reg <= in_coord;
            cur_tag_reg   <= in_tag;
            cur_flags_reg <= in_flags;
        end
        if (take && active)
        begin
            prev_coord_reg <= cur_coord_reg;
            prev_tag_reg   <= cur_tag_reg;
        end
        if (out_load)
        begin
            out_coord_reg <= emit_coord;
            out_tag_reg   <= emit_tag;
            out_flags_reg <= emit_flags;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_coord = out_coord_reg;
    assign out_tag   = out_tag_reg;
    assign out_flags = out_flags_reg;

endmodule

// File: sv/chaikin_corner_cutting.sv
// Throughput: one output word per cycle while m_axis_tready is high; a point yields up to
// 2^(levels+1)-1 words, so on a long polyline the last active level sets the input pace.
// Levels beyond the configured count pass words through unchanged.
// Reset (rst_n low, asynchronous) empties the queue, clears the valid and history flags
// of every level and sets levels to 1.
module chaikin_corner_cutting #(
    parameter int MAX_LEVELS  = cc_pkg::CC_MAX_LEVELS,
    parameter int COORD_WIDTH = cc_pkg::CC_COORD_WIDTH,
    parameter int TAG_WIDTH   = cc_pkg::CC_TAG_WIDTH
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // px, py, pz, point_tag
    input  logic [((3*COORD_WIDTH+TAG_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                         s_axis_tlast,  // end_of_path
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // qx, qy, qz, out_tag
    output logic [((3*COORD_WIDTH+TAG_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                                         m_axis_tlast,  // last_of_run
    output logic [0:0]                                   m_axis_tuser,  // path_done
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [cc_pkg::CC_LEVELS_W-1:0]               cfg_data
);
    import cc_pkg::*;

    localparam int DATA_W = ((3*COORD_WIDTH + TAG_WIDTH + 7) / 8) * 8;

    logic                        f_valid;
    logic                        f_ready;
    logic [2:0][COORD_WIDTH-1:0] f_coord;
    logic [TAG_WIDTH-1:0]        f_tag;
    cc_flags_t                   f_flags;

    logic [MAX_LEVELS:0]                    st_valid;
    logic [MAX_LEVELS:0]                    st_ready;
    logic [MAX_LEVELS:0][2:0][COORD_WIDTH-1:0] st_coord;
    logic [MAX_LEVELS:0][TAG_WIDTH-1:0]     st_tag;
    cc_flags_t [MAX_LEVELS:0]               st_flags;

    cc_front #(
        .MAX_LEVELS  (MAX_LEVELS),
        .COORD_WIDTH (COORD_WIDTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .q_valid       (f_valid),
        .q_ready       (f_ready),
        .q_coord       (f_coord),
        .q_tag         (f_tag),
        .q_flags       (f_flags)
    );

    cc_queue #(
        .COORD_WIDTH (COORD_WIDTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_coord  (f_coord),
        .in_tag    (f_tag),
        .in_flags  (f_flags),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_coord (st_coord[0]),
        .out_tag   (st_tag[0]),
        .out_flags (st_flags[0])
    );

    for (genvar i = 0; i < MAX_LEVELS; i++)
    begin : g_level
        cc_level #(
            .LEVEL_IDX   (i),
            .COORD_WIDTH (COORD_WIDTH),
            .TAG_WIDTH   (TAG_WIDTH)
        ) u_level (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_coord  (st_coord[i]),
            .in_tag    (st_tag[i]),
            .in_flags  (st_flags[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_coord (st_coord[i+1]),
            .out_tag   (st_tag[i+1]),
            .out_flags (st_flags[i+1])
        );
    end

    assign m_axis_tvalid           = st_valid[MAX_LEVELS];
    assign st_ready[MAX_LEVELS]    = m_axis_tready;
    assign m_axis_tdata            = DATA_W'({st_tag[MAX_LEVELS], st_coord[MAX_LEVELS]});
    assign m_axis_tlast            = st_flags[MAX_LEVELS].run_last;
    assign m_axis_tuser[0]         = st_flags[MAX_LEVELS].path_end;

endmodule

// File: bench/tb_chaikin_corner_cutting.sv
// Self-checking bench for the Chaikin corner-cutting smoother: directed table, then random paths.
module tb_chaikin_corner_cutting;

    timeunit 1ns;
    timeprecision 1ps;

    import cc_pkg::*;

    localparam int CW          = CC_COORD_WIDTH;
    localparam int TW          = CC_TAG_WIDTH;
    localparam int DW          = ((3*CW+TW+7)/8)*8;
    localparam int LAT         = 2*CC_MAX_LEVELS+1;
    localparam int ITEMS_TOTAL = 170;
    localparam int NO_CFG      = -1;

    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] C_M1  = {CW{1'b1}};

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [TW-1:0] tag;
        logic          eop;
    } point_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [TW-1:0] tag;
        logic          run_last;
        logic          path_done;
    } word_t;

    // one directed row; echo rows expect the point repeated 2^levels times
    typedef struct packed {
        int            cfg;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [TW-1:0] tag;
        logic          eop;
        logic          echo;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [DW-1:0]          s_axis_tdata   = '0;
    logic                   s_axis_tlast   = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [DW-1:0]          m_axis_tdata;
    logic                   m_axis_tlast;
    logic [0:0]             m_axis_tuser;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CC_LEVELS_W-1:0] cfg_data       = '0;

    // predictor state
    logic [CC_LEVELS_W-1:0] levels_reg;
    point_t                 lvl_prev [CC_MAX_LEVELS];
    logic                   lvl_open [CC_MAX_LEVELS];

    word_t pending_words [$];
    int    mismatch_count = 0;
    int    items_sent     = 0;
    int    tx_odds        = 0;
    int    rx_odds        = 0;
    int    rx_hold        = 0;

    chaikin_corner_cutting u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int eff_levels(input logic [CC_LEVELS_W-1:0] v);
        if (v == 0)
            return 1;
        if (int'(v) > CC_MAX_LEVELS)
            return CC_MAX_LEVELS;
        return int'(v);
    endfunction

    // floor((3a + b) / 4), signed
    function automatic logic [CW-1:0] cut_mix(input logic [CW-1:0] a, input logic [CW-1:0] b);
        longint acc;
        acc = 3 * longint'($signed(a)) + longint'($signed(b));
        return CW'(acc >>> 2);
    endfunction

    function automatic void smooth_point(input point_t p_in, output word_t outs [$]);
        point_t src [$];
        point_t dst [$];
        point_t p;
        point_t q;
        point_t r;
        word_t  w;
        int     nl;
        nl = eff_levels(levels_reg);
        outs.delete();
        src.insert(src.size(), p_in);
        for (int lv = 0; lv < nl; lv++)
        begin
            dst.delete();
            foreach (src[i])
            begin
                p = src[i];
                if (!lvl_open[lv])
                begin
                    q     = p;
                    q.eop = 1'b0;
                    dst.insert(dst.size(), q);
                end
                else
                begin
                    q.x   = cut_mix(lvl_prev[lv].x, p.x);
                    q.y   = cut_mix(lvl_prev[lv].y, p.y);
                    q.z   = cut_mix(lvl_prev[lv].z, p.z);
                    q.tag = lvl_prev[lv].tag;
                    q.eop = 1'b0;
                    r.x   = cut_mix(p.x, lvl_prev[lv].x);
                    r.y   = cut_mix(p.y, lvl_prev[lv].y);
                    r.z   = cut_mix(p.z, lvl_prev[lv].z);
                    r.tag = p.tag;
                    r.eop = 1'b0;
                    dst.insert(dst.size(), q);
                    dst.insert(dst.size(), r);
                end
                lvl_prev[lv] = p;
                lvl_open[lv] = 1'b1;
                if (p.eop)
                begin
                    dst.insert(dst.size(), p);
                    lvl_open[lv] = 1'b0;
                end
            end
            src = dst;
        end
        foreach (src[k])
        begin
            w.x         = src[k].x;
            w.y         = src[k].y;
            w.z         = src[k].z;
            w.tag       = src[k].tag;
            w.run_last  = (k == src.size() - 1);
            w.path_done = src[k].eop;
            outs.insert(outs.size(), w);
        end
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 6))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return CW'($urandom_range(0, 16)) - CW'(8);
            3:       return CW'($urandom_range(0, 32'h3ffff)) - CW'(32'h20000);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic send_point(input point_t p);
        if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tdata  <= DW'({p.tag, p.z, p.y, p.x});
        s_axis_tlast  <= p.eop;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic queue_and_send(input point_t p);
        word_t outs [$];
        smooth_point(p, outs);
        foreach (outs[k])
            pending_words.insert(pending_words.size(), outs[k]);
        send_point(p);
    endtask

    // register only changes with the pipeline empty
    task automatic write_levels(input logic [CC_LEVELS_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (LAT) @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        levels_reg = v;
    endtask

    // output side: random back-pressure and the scoreboard
    always @(posedge clk)
    begin
        word_t w;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected output word: %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (m_axis_tdata[CW-1:0] !== w.x)
                begin
                    $error("qx: expected %0d, got %0d", $signed(w.x),
                           $signed(m_axis_tdata[CW-1:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[2*CW-1:CW] !== w.y)
                begin
                    $error("qy: expected %0d, got %0d", $signed(w.y),
                           $signed(m_axis_tdata[2*CW-1:CW]));
                    mismatch_count++;
                end
                if (m_axis_tdata[3*CW-1:2*CW] !== w.z)
                begin
                    $error("qz: expected %0d, got %0d", $signed(w.z),
                           $signed(m_axis_tdata[3*CW-1:2*CW]));
                    mismatch_count++;
                end
                if (m_axis_tdata[3*CW+TW-1:3*CW] !== w.tag)
                begin
                    $error("out_tag: expected %h, got %h", w.tag,
                           m_axis_tdata[3*CW+TW-1:3*CW]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== w.run_last)
                begin
                    $error("last_of_run: expected %b, got %b", w.run_last, m_axis_tlast);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== w.path_done)
                begin
                    $error("path_done: expected %b, got %b", w.path_done, m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
        if (rx_hold != 0)
        begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1)
        begin
            rx_hold       <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        dir_row_t dir_tab [24];
        dir_row_t row;
        point_t   p;
        word_t    w;
        word_t    outs [$];
        int       n_paths;
        int       len;
        int       n_echo;
        bit       broken;

        levels_reg = 3'd1;
        for (int i = 0; i < CC_MAX_LEVELS; i++)
        begin
            lvl_prev[i] = '0;
            lvl_open[i] = 1'b0;
        end

        dir_tab = '{
            // levels straight after reset
            '{NO_CFG, 32'h00010000, 32'h00020000, 32'hfffd0000, 16'h0001, 1'b1, 1'b1},
            '{NO_CFG, C_MAX,        C_MAX,        C_MAX,        16'hffff, 1'b1, 1'b1},
            '{NO_CFG, C_MIN,        C_MIN,        C_MIN,        16'h0000, 1'b1, 1'b1},
            '{NO_CFG, C_MAX,        C_MIN,        32'h0,        16'h0010, 1'b0, 1'b0},
            '{NO_CFG, C_MIN,        C_MAX,        C_M1,         16'h0011, 1'b0, 1'b0},
            '{NO_CFG, C_M1,         32'h0,        32'h1,        16'h0012, 1'b1, 1'b0},
            '{4,      32'h00008000, 32'h7fff0000, 32'h80010000, 16'ha5a5, 1'b1, 1'b1},
            // zero acts as one level
            '{0,      32'h12345678, 32'hedcba987, 32'h0,        16'h5a5a, 1'b1, 1'b1},
            // seven clamps to four
            '{7,      C_MIN,        C_MIN,        C_MAX,        16'h0100, 1'b0, 1'b0},
            '{NO_CFG, C_MAX,        C_MAX,        C_MIN,        16'h0101, 1'b1, 1'b0},
            // floor of negative quarters
            '{2,      C_M1,         32'h0,        32'hfffffffe, 16'h0200, 1'b0, 1'b0},
            '{NO_CFG, 32'h0,        C_M1,         32'h1,        16'h0201, 1'b0, 1'b0},
            '{NO_CFG, 32'h3,        32'hfffffffd, 32'h0,        16'h0202, 1'b1, 1'b0},
            '{5,      32'hdeadbeef, 32'h00000001, 32'h80000001, 16'h8001, 1'b1, 1'b1},
            '{3,      32'h00100000, 32'hfff00000, 32'h00000400, 16'h0300, 1'b0, 1'b0},
            '{NO_CFG, 32'h00200000, 32'hffe00000, 32'hfffffc00, 16'h0301, 1'b0, 1'b0},
            '{NO_CFG, 32'h00000000, 32'h00000000, 32'h00000000, 16'h0302, 1'b1, 1'b0},
            // levels raised mid-path
            '{1,      32'h00050000, 32'h00060000, 32'h00070000, 16'h0400, 1'b0, 1'b0},
            '{NO_CFG, 32'hfffb0000, 32'h00010000, 32'h00020000, 16'h0401, 1'b0, 1'b0},
            '{4,      32'h00030000, 32'hffff0000, 32'h00000000, 16'h0402, 1'b0, 1'b0},
            '{NO_CFG, 32'h7ff00000, 32'h80100000, 32'h00001234, 16'h0403, 1'b1, 1'b0},
            // levels lowered mid-path: the upper levels keep their open point
            '{NO_CFG, 32'h00011111, 32'h00022222, 32'h00033333, 16'h0500, 1'b0, 1'b0},
            '{2,      32'hfff11111, 32'hfff22222, 32'hfff33333, 16'h0501, 1'b0, 1'b0},
            '{NO_CFG, 32'h00000abc, 32'hffffff00, 32'h00000100, 16'h0502, 1'b1, 1'b0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_odds = 4;
        rx_odds = 5;
        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            if (row.cfg != NO_CFG)
                write_levels(CC_LEVELS_W'(row.cfg));
            p = '{x: row.x, y: row.y, z: row.z, tag: row.tag, eop: row.eop};
            smooth_point(p, outs);
            if (row.echo)
            begin
                // lone point: every level repeats it, so 2^levels copies
                outs.delete();
                n_echo = 1 << eff_levels(levels_reg);
                for (int k = 0; k < n_echo; k++)
                begin
                    w = '{x: row.x, y: row.y, z: row.z, tag: row.tag,
                          run_last: (k == n_echo - 1), path_done: (k == n_echo - 1)};
                    outs.insert(outs.size(), w);
                end
            end
            foreach (outs[k])
                pending_words.insert(pending_words.size(), outs[k]);
            send_point(p);
        end

        while (items_sent < ITEMS_TOTAL)
        begin
            if (items_sent >= ITEMS_TOTAL - 25)
            begin
                tx_odds = 0;
                rx_odds = 0;
            end
            else
            begin
                tx_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
                rx_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
            end
            write_levels(CC_LEVELS_W'($urandom_range(0, 7)));
            n_paths = $urandom_range(1, 4);
            repeat (n_paths)
            begin
                len    = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 10)
                                                      : $urandom_range(1, 4);
                broken = ($urandom_range(0, 7) == 0);
                for (int i = 0; i < len; i++)
                begin
                    p.x   = rand_coord();
                    p.y   = rand_coord();
                    p.z   = rand_coord();
                    p.tag = TW'($urandom);
                    p.eop = (i == len - 1) && !broken;
                    queue_and_send(p);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4*LAT) @(posedge clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
